FILE: src/satl_pkg.sv
// ----------------------------------------------------------------------------
// satl_pkg
// Shared types and constants of the set-associative tag lookup: port field
// widths, access codes, controller states and the controller/datapath links.
// ----------------------------------------------------------------------------
package satl_pkg;

    localparam int TAG_W     = 28;
    localparam int SET_IDX_W = 6;
    localparam int VICTIM_W  = 3;
    localparam int WAY_OUT_W = 3;
    localparam int CNT_W     = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESOLVE
    } state_t;

    typedef struct packed {
        logic clear_en;
        logic capture;
        logic resolve;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } status_t;

endpackage

FILE: src/satl_ctrl.sv
// ----------------------------------------------------------------------------
// satl_ctrl
// Sequencer of the tag lookup: clears the directory after reset, then takes
// one access, resolves it against the registered set row and hands it on.
// ----------------------------------------------------------------------------
module satl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  satl_pkg::status_t  status,
    output satl_pkg::cmd_t     cmd
);

    satl_pkg::state_t state_reg;
    satl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= satl_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.clear_en = 1'b0;
        cmd.capture  = 1'b0;
        cmd.resolve  = 1'b0;
        in_stall     = 1'b1;
        unique case (state_reg)
            satl_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = satl_pkg::ST_IDLE;
                end
            end
            satl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = satl_pkg::ST_RESOLVE;
                end
            end
            satl_pkg::ST_RESOLVE:
            begin
                // hold until the previous result word has left
                if (!status.out_blocked)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = satl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = satl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/satl_dp.sv
// ----------------------------------------------------------------------------
// satl_dp
// Datapath of the tag lookup: set-row memory of valid bits and tags, the
// parallel way compare, fill selection, saturating counters and result word.
// ----------------------------------------------------------------------------
module satl_dp
#(
    parameter int NUM_SETS = 64,
    parameter int NUM_WAYS = 8,
    parameter int TAG_BITS = 28
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  satl_pkg::cmd_t                      cmd,
    output satl_pkg::status_t                   status,
    input  logic                                action,
    input  logic [satl_pkg::SET_IDX_W-1:0]      set_index,
    input  logic [satl_pkg::TAG_W-1:0]          tag,
    input  logic [satl_pkg::VICTIM_W-1:0]       victim_way,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic                                filled,
    output logic                                evicted,
    output logic [satl_pkg::WAY_OUT_W-1:0]      way,
    output logic [satl_pkg::CNT_W-1:0]          hit_total,
    output logic [satl_pkg::CNT_W-1:0]          miss_total
);

    localparam int SB    = (TAG_BITS < satl_pkg::TAG_W) ? TAG_BITS : satl_pkg::TAG_W;
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ROW_W = NUM_WAYS * (SB + 1);

    // row layout: valid bits low, then one tag per way
    logic [ROW_W-1:0] mem [NUM_SETS];

    logic [ROW_W-1:0]              row_reg;
    logic [SET_W-1:0]              clr_cnt_reg;
    logic                          action_reg;
    logic [SET_W-1:0]              set_reg;
    logic                          in_range_reg;
    logic [SB-1:0]                 tag_reg;
    logic [satl_pkg::VICTIM_W-1:0] victim_reg;
    logic [satl_pkg::CNT_W-1:0]    hit_cnt_reg;
    logic [satl_pkg::CNT_W-1:0]    hit_cnt_next;
    logic [satl_pkg::CNT_W-1:0]    miss_cnt_reg;
    logic [satl_pkg::CNT_W-1:0]    miss_cnt_next;
    logic                          out_valid_reg;
    logic                          hit_reg;
    logic                          filled_reg;
    logic                          evicted_reg;
    logic [satl_pkg::WAY_OUT_W-1:0] way_reg;

    logic [SET_W+satl_pkg::SET_IDX_W-1:0] set_ext;
    logic [SET_W-1:0]              rd_addr;
    logic [NUM_WAYS-1:0]           valid_vec;
    logic [NUM_WAYS-1:0]           match_vec;
    logic                          found;
    logic                          has_inv;
    logic [WAY_W-1:0]              hit_way;
    logic [WAY_W-1:0]              inv_way;
    logic [5:0]                    victim_mod;
    logic [WAY_W-1:0]              fill_way;
    logic                          res_hit;
    logic                          res_miss;
    logic                          res_fill;
    logic                          res_evict;
    logic [WAY_W-1:0]              res_way;
    logic [WAY_W+satl_pkg::WAY_OUT_W-1:0] way_ext;
    logic [ROW_W-1:0]              new_row;

    assign set_ext = {{SET_W{1'b0}}, set_index};
    assign rd_addr = set_ext[SET_W-1:0];

    // memory: clearing sweep, row write-back, registered row read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.resolve && res_fill)
        begin
            mem[set_reg] <= new_row;
        end
        if (cmd.capture)
        begin
            row_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign status.clear_last  = (clr_cnt_reg == SET_W'(NUM_SETS - 1));
    assign status.out_blocked = out_valid_reg && out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg   <= action;
            set_reg      <= rd_addr;
            in_range_reg <= ({7'd0, set_index} < 13'(NUM_SETS));
            tag_reg      <= tag[SB-1:0];
            victim_reg   <= victim_way;
        end
    end

    always_comb
    begin
        valid_vec = row_reg[NUM_WAYS-1:0];
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            match_vec[w] = valid_vec[w] && (row_reg[NUM_WAYS + w*SB +: SB] == tag_reg);
        end
        found   = |match_vec;
        has_inv = ~&valid_vec;
        hit_way = '0;
        inv_way = '0;
        // lowest index wins
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (match_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (!valid_vec[w])
            begin
                inv_way = WAY_W'(w);
            end
        end
    end

    // victim modulo way count, a few narrow subtract steps
    always_comb
    begin
        victim_mod = {3'd0, victim_reg};
        for (int i = 0; i < 8; i++)
        begin
            if (victim_mod >= 6'(NUM_WAYS))
            begin
                victim_mod = victim_mod - 6'(NUM_WAYS);
            end
        end
    end

    always_comb
    begin
        res_hit   = in_range_reg && found;
        res_miss  = in_range_reg && !found;
        res_fill  = res_miss && (action_reg == satl_pkg::ACT_READ);
        res_evict = res_fill && !has_inv;
        fill_way  = has_inv ? inv_way : victim_mod[WAY_W-1:0];
        if (res_hit)
        begin
            res_way = hit_way;
        end
        else if (res_fill)
        begin
            res_way = fill_way;
        end
        else
        begin
            res_way = '0;
        end
        way_ext = {{satl_pkg::WAY_OUT_W{1'b0}}, res_way};
        new_row = row_reg;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (WAY_W'(w) == fill_way)
            begin
                new_row[w]                    = 1'b1;
                new_row[NUM_WAYS + w*SB +: SB] = tag_reg;
            end
        end
    end

    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (res_hit && (hit_cnt_reg != satl_pkg::CNT_MAX))
        begin
            hit_cnt_next = hit_cnt_reg + 1'b1;
        end
        if (res_miss && (miss_cnt_reg != satl_pkg::CNT_MAX))
        begin
            miss_cnt_next = miss_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.resolve)
            begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            hit_reg     <= res_hit;
            filled_reg  <= res_fill;
            evicted_reg <= res_evict;
            way_reg     <= way_ext[satl_pkg::WAY_OUT_W-1:0];
        end
    end

    // counters only move on resolve, which waits for the word to leave
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign filled     = filled_reg;
    assign evicted    = evicted_reg;
    assign way        = way_reg;
    assign hit_total  = hit_cnt_reg;
    assign miss_total = miss_cnt_reg;

endmodule

FILE: src/set_assoc_cache_tag_lookup_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_top
// Tag directory of a NUM_WAYS-way, NUM_SETS-set cache with given-way
// replacement. Each access word is compared against every valid way of its
// set; a read miss fills the lowest invalid way, or victim_way when the set
// is full, and a write miss only counts. One result word per access carries
// hit/fill/evict flags, the way, and saturating hit and miss totals. After
// reset the block sweeps all NUM_SETS rows of the set memory, one row a
// cycle, before it takes the first access. In capture, an access reads its
// set row from the single-port row memory into a register; in resolve, it is
// compared, the way is picked and the updated row written back. The result
// register lets a new access enter while the previous result waits.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_top
#(
    parameter int NUM_SETS = 64,
    parameter int NUM_WAYS = 8,
    parameter int TAG_BITS = 28
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic [satl_pkg::SET_IDX_W-1:0]      set_index,
    input  logic [satl_pkg::TAG_W-1:0]          tag,
    input  logic [satl_pkg::VICTIM_W-1:0]       victim_way,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic                                filled,
    output logic                                evicted,
    output logic [satl_pkg::WAY_OUT_W-1:0]      way,
    output logic [satl_pkg::CNT_W-1:0]          hit_total,
    output logic [satl_pkg::CNT_W-1:0]          miss_total
);

    satl_pkg::cmd_t    cmd;
    satl_pkg::status_t status;

    satl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    satl_dp
    #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS),
        .TAG_BITS (TAG_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .action     (action),
        .set_index  (set_index),
        .tag        (tag),
        .victim_way (victim_way),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .filled     (filled),
        .evicted    (evicted),
        .way        (way),
        .hit_total  (hit_total),
        .miss_total (miss_total)
    );

`ifndef NO_ASSERTIONS
    // an accepted access occupies the block for its resolve cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("access accepted while previous one unresolved");

    // a result word is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resolve |-> !(out_valid && out_stall))
        else $error("resolve while result word stalled");

    // totals never go backwards
    a_hits_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (hit_total >= $past(hit_total)))
        else $error("hit total decreased");

    a_miss_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (miss_total >= $past(miss_total)))
        else $error("miss total decreased");
`endif

endmodule

FILE: sim/set_assoc_cache_tag_lookup_top_tb.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_top_tb
// Self-checking bench for the set-associative tag lookup. A directory model
// in the bench tracks valid bits, tags and the hit/miss totals. It predicts
// one result word per accepted access. Directed accesses cover cold fills,
// read and write hits, write misses and evictions from full sets. Random
// traffic then reuses a small pool of tags per set, so hits, fills and
// evictions all occur often. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS      = 64;
    localparam int WAYS      = 8;
    localparam int POOL_TAGS = 12;

    typedef struct packed {
        logic                           hit;
        logic                           filled;
        logic                           evicted;
        logic [satl_pkg::WAY_OUT_W-1:0] way;
        logic [satl_pkg::CNT_W-1:0]     hit_total;
        logic [satl_pkg::CNT_W-1:0]     miss_total;
    } lookup_result_t;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           in_valid   = 1'b0;
    logic                           in_stall;
    logic                           action     = satl_pkg::ACT_READ;
    logic [satl_pkg::SET_IDX_W-1:0] set_index  = '0;
    logic [satl_pkg::TAG_W-1:0]     tag        = '0;
    logic [satl_pkg::VICTIM_W-1:0]  victim_way = '0;
    logic                           out_valid;
    logic                           out_stall  = 1'b0;
    logic                           hit;
    logic                           filled;
    logic                           evicted;
    logic [satl_pkg::WAY_OUT_W-1:0] way;
    logic [satl_pkg::CNT_W-1:0]     hit_total;
    logic [satl_pkg::CNT_W-1:0]     miss_total;

    // directory model
    logic                       dir_valid [SETS][WAYS];
    logic [satl_pkg::TAG_W-1:0] dir_tag   [SETS][WAYS];
    logic [satl_pkg::CNT_W-1:0] model_hits;
    logic [satl_pkg::CNT_W-1:0] model_misses;

    lookup_result_t             pending_results[$];
    logic [satl_pkg::TAG_W-1:0] tag_pool [SETS][POOL_TAGS];

    int fail_count     = 0;
    int words_checked  = 0;
    int n_reads        = 0;
    int n_writes       = 0;
    int n_hits         = 0;
    int n_fills        = 0;
    int n_evictions    = 0;
    int n_write_misses = 0;
    int burst_left     = 0;

    set_assoc_cache_tag_lookup_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .set_index  (set_index),
        .tag        (tag),
        .victim_way (victim_way),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .filled     (filled),
        .evicted    (evicted),
        .way        (way),
        .hit_total  (hit_total),
        .miss_total (miss_total)
    );

    always #5 clk = ~clk;

    function automatic lookup_result_t predict_lookup(
        input logic                           act,
        input logic [satl_pkg::SET_IDX_W-1:0] set_i,
        input logic [satl_pkg::TAG_W-1:0]     tag_i,
        input logic [satl_pkg::VICTIM_W-1:0]  victim
    );
        lookup_result_t r;
        logic           found;
        logic           placed;
        int             vw;
        r      = '0;
        found  = 1'b0;
        placed = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && dir_valid[set_i][w] && dir_tag[set_i][w] == tag_i)
            begin
                found = 1'b1;
                r.way = w[satl_pkg::WAY_OUT_W-1:0];
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            if (model_hits != satl_pkg::CNT_MAX)
                model_hits = model_hits + 1'b1;
        end
        else
        begin
            if (model_misses != satl_pkg::CNT_MAX)
                model_misses = model_misses + 1'b1;
            if (act == satl_pkg::ACT_READ)
            begin
                // lowest invalid way first, the given way only when the set is full
                for (int w = 0; w < WAYS; w++)
                begin
                    if (!placed && !dir_valid[set_i][w])
                    begin
                        placed = 1'b1;
                        r.way  = w[satl_pkg::WAY_OUT_W-1:0];
                    end
                end
                if (!placed)
                begin
                    vw        = victim % WAYS;
                    r.way     = vw[satl_pkg::WAY_OUT_W-1:0];
                    r.evicted = 1'b1;
                end
                dir_valid[set_i][r.way] = 1'b1;
                dir_tag[set_i][r.way]   = tag_i;
                r.filled                = 1'b1;
            end
        end
        r.hit_total  = model_hits;
        r.miss_total = model_misses;
        return r;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [satl_pkg::CNT_W-1:0] exp_v,
                                        input logic [satl_pkg::CNT_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    task automatic send_word(input logic act, input logic [satl_pkg::SET_IDX_W-1:0] set_i,
                             input logic [satl_pkg::TAG_W-1:0] tag_i,
                             input logic [satl_pkg::VICTIM_W-1:0] victim);
        lookup_result_t r;
        int             gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        action     <= act;
        set_index  <= set_i;
        tag        <= tag_i;
        victim_way <= victim;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_lookup(act, set_i, tag_i, victim);
        pending_results.push_back(r);
        if (act == satl_pkg::ACT_READ)
            n_reads++;
        else
            n_writes++;
        n_hits      += r.hit;
        n_fills     += r.filled;
        n_evictions += r.evicted;
        if (act == satl_pkg::ACT_WRITE && !r.hit)
            n_write_misses++;
        // bursts of back-to-back words with idle gaps between them
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_basic_access();
        send_word(satl_pkg::ACT_READ,  6'd0,  28'h0000000, 3'd0);
        send_word(satl_pkg::ACT_READ,  6'd0,  28'h0000000, 3'd7);
        send_word(satl_pkg::ACT_WRITE, 6'd0,  28'h0000000, 3'd0);
        send_word(satl_pkg::ACT_WRITE, 6'd0,  28'hFFFFFFF, 3'd7);
        send_word(satl_pkg::ACT_READ,  6'd63, 28'hFFFFFFF, 3'd7);
        send_word(satl_pkg::ACT_WRITE, 6'd63, 28'hFFFFFFF, 3'd0);
        send_word(satl_pkg::ACT_READ,  6'd63, 28'h0000000, 3'd0);
        send_word(satl_pkg::ACT_READ,  6'd42, 28'h5555555, 3'd2);
        send_word(satl_pkg::ACT_READ,  6'd21, 28'hAAAAAAA, 3'd5);
        wait_all_results();
    endtask

    task automatic test_full_set_eviction();
        for (int i = 0; i < WAYS; i++)
            send_word(satl_pkg::ACT_READ, 6'd5, satl_pkg::TAG_W'(28'h0000100 + i),
                      3'($urandom_range(0, 7)));
        send_word(satl_pkg::ACT_READ,  6'd5, 28'h0000200, 3'd7);
        send_word(satl_pkg::ACT_READ,  6'd5, 28'h0000201, 3'd0);
        send_word(satl_pkg::ACT_READ,  6'd5, 28'h0000103, 3'd1);
        // tag pushed out above comes back and evicts another way
        send_word(satl_pkg::ACT_READ,  6'd5, 28'h0000107, 3'd4);
        send_word(satl_pkg::ACT_WRITE, 6'd5, 28'h0000100, 3'd2);
        send_word(satl_pkg::ACT_WRITE, 6'd5, 28'h0000200, 3'd6);
        wait_all_results();
    endtask

    task automatic test_random_traffic(input int n_words);
        logic                           act;
        logic [satl_pkg::SET_IDX_W-1:0] set_i;
        logic [satl_pkg::TAG_W-1:0]     tag_i;
        for (int s = 0; s < SETS; s++)
            for (int t = 0; t < POOL_TAGS; t++)
                tag_pool[s][t] = satl_pkg::TAG_W'($urandom);
        for (int i = 0; i < n_words; i++)
        begin
            set_i = satl_pkg::SET_IDX_W'($urandom_range(0, SETS - 1));
            if ($urandom_range(0, 99) < 85)
            begin
                // reuse of a few tags per set makes hits and evictions common
                act   = ($urandom_range(0, 99) < 70) ? satl_pkg::ACT_READ
                                                     : satl_pkg::ACT_WRITE;
                tag_i = tag_pool[set_i][$urandom_range(0, POOL_TAGS - 1)];
            end
            else
            begin
                act   = $urandom_range(0, 1) ? satl_pkg::ACT_WRITE : satl_pkg::ACT_READ;
                tag_i = satl_pkg::TAG_W'($urandom);
            end
            send_word(act, set_i, tag_i, satl_pkg::VICTIM_W'($urandom_range(0, 7)));
            if (i == n_words / 2)
                wait_all_results();
        end
        wait_all_results();
    endtask

    // receiver stalls in modes that change every so often
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 25);
            2:       out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= ((stall_left / 8) % 2 == 1);
        endcase
    end

    always @(posedge clk)
    begin : check_result
        lookup_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result word with nothing expected, hit=%0b way=%0d",
                         $time, hit, way);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("hit",        satl_pkg::CNT_W'(exp_r.hit),
                            satl_pkg::CNT_W'(hit));
                check_field("filled",     satl_pkg::CNT_W'(exp_r.filled),
                            satl_pkg::CNT_W'(filled));
                check_field("evicted",    satl_pkg::CNT_W'(exp_r.evicted),
                            satl_pkg::CNT_W'(evicted));
                check_field("way",        satl_pkg::CNT_W'(exp_r.way),
                            satl_pkg::CNT_W'(way));
                check_field("hit_total",  exp_r.hit_total,  hit_total);
                check_field("miss_total", exp_r.miss_total, miss_total);
                words_checked++;
            end
        end
    end

    initial
    begin
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++)
            begin
                dir_valid[s][w] = 1'b0;
                dir_tag[s][w]   = '0;
            end
        model_hits   = '0;
        model_misses = '0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_access();
        test_full_set_eviction();
        test_random_traffic(1830);

        repeat (16)
            @(posedge clk);
        $display("checked %0d result words: %0d reads, %0d writes, %0d hits",
                 words_checked, n_reads, n_writes, n_hits);
        $display("fills %0d, evictions %0d, write misses %0d, words left over %0d",
                 n_fills, n_evictions, n_write_misses, pending_results.size());
        if (fail_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d result words outstanding", pending_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
